>>> rtl/core/gdec_pkg.sv
// shared types, constants and register indexes for the gamepad conditioner
package gdec_pkg;

    localparam int AXIS_W = 16;
    localparam int MAG_W  = 15;
    localparam int NUM_W  = 2 * MAG_W;
    localparam int BTN_W  = 16;
    localparam int TRIG_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int NUM_AXES   = 4;
    localparam int AXIS_IDX_W = $clog2(NUM_AXES);
    localparam int DIV_STEPS  = MAG_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [MAG_W-1:0]  FULL_SCALE     = 15'h7fff;
    localparam int                SPRINT_BIT     = 12;
    localparam logic [MAG_W-1:0]  RESET_LEFT_DZ  = 15'd7849;
    localparam logic [MAG_W-1:0]  RESET_RIGHT_DZ = 15'd8689;
    localparam logic [TRIG_W-1:0] RESET_TRIG_THR = 8'd30;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_THR  = 2'd3;

    localparam logic [AXIS_IDX_W-1:0] AXIS_LX = 2'd0;
    localparam logic [AXIS_IDX_W-1:0] AXIS_LY = 2'd1;
    localparam logic [AXIS_IDX_W-1:0] AXIS_RX = 2'd2;
    localparam logic [AXIS_IDX_W-1:0] AXIS_RY = 2'd3;

    typedef struct packed {
        logic                     connected;
        logic [BTN_W-1:0]         buttons_in;
        logic signed [AXIS_W-1:0] left_x_in;
        logic signed [AXIS_W-1:0] left_y_in;
        logic signed [AXIS_W-1:0] right_x_in;
        logic signed [AXIS_W-1:0] right_y_in;
        logic [TRIG_W-1:0]        left_trigger_in;
        logic [TRIG_W-1:0]        right_trigger_in;
    } in_item_t;

    typedef struct packed {
        logic [BTN_W-1:0]         buttons_out;
        logic signed [AXIS_W-1:0] left_x_out;
        logic signed [AXIS_W-1:0] left_y_out;
        logic signed [AXIS_W-1:0] right_x_out;
        logic signed [AXIS_W-1:0] right_y_out;
        logic [TRIG_W-1:0]        left_trigger_out;
        logic [TRIG_W-1:0]        right_trigger_out;
        logic                     aiming;
        logic                     shooting;
        logic                     sprinting;
        logic [BTN_W-1:0]         pressed_mask;
        logic [BTN_W-1:0]         released_mask;
    } out_item_t;

    typedef struct packed {
        logic                  capture;
        logic                  axis_load;
        logic                  div_step;
        logic                  axis_store;
        logic                  out_load;
        logic [AXIS_IDX_W-1:0] axis_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic axis_zero;
    } ctrl_sts_t;

endpackage

>>> rtl/core/gamepad_deadzone_edge_conditioner_unit.sv
// top level of the gamepad deadzone and button edge conditioner
// Takes one gamepad poll per transfer and returns one conditioned result. Each stick
// axis gets an axial deadzone and is rescaled to full range through a shared radix-2
// divider, one quotient bit per cycle. After the poll's transfer each axis in turn gets
// one setup, fifteen divide steps and one store, then the result register is loaded;
// an axis that falls inside its deadzone skips its divide steps. The next poll can be
// accepted the cycle after the output load, so a new poll is not taken while the last
// one is still being conditioned. The output load waits while an earlier result is
// still stalled. A finished result waits in the output register while the next poll
// is accepted. Configuration writes take effect at once and should be made while idle.
module gamepad_deadzone_edge_conditioner_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [gdec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdec_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gdec_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gdec_pkg::out_item_t             out_data
);
    import gdec_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    gdec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gdec_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/gdec_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit in fifteen bits
module gdec_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        step,
    input  logic [gdec_pkg::NUM_W-1:0]  numerator,
    input  logic [gdec_pkg::MAG_W-1:0]  divisor,
    output logic [gdec_pkg::MAG_W-1:0]  quotient
);
    import gdec_pkg::*;

    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [MAG_W-1:0] dvs_reg, dvs_next;
    logic [MAG_W:0]   shifted;
    logic [MAG_W:0]   trial;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[MAG_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (load)
        begin
            rem_next = numerator[NUM_W-1:MAG_W];
            quo_next = numerator[MAG_W-1:0];
            dvs_next = divisor;
        end
        else if (step)
        begin
            if (!trial[MAG_W])
            begin
                rem_next = trial[MAG_W-1:0];
            end
            else
            begin
                rem_next = shifted[MAG_W-1:0];
            end
            quo_next = {quo_reg[MAG_W-2:0], ~trial[MAG_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            dvs_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs_next;
        end
    end

    assign quotient = quo_reg;

endmodule

>>> rtl/core/gdec_datapath.sv
// datapath: config registers, poll capture, axis conditioning and output register
module gdec_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [gdec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdec_pkg::CFG_DATA_W-1:0] cfg_data,
    input  gdec_pkg::in_item_t              in_data,
    input  gdec_pkg::ctrl_cmd_t             cmd,
    output gdec_pkg::ctrl_sts_t             sts,
    output gdec_pkg::out_item_t             out_data
);
    import gdec_pkg::*;

    logic [MAG_W-1:0]  ldz_reg, ldz_next;
    logic [MAG_W-1:0]  rdz_reg, rdz_next;
    logic [TRIG_W-1:0] lthr_reg, lthr_next;
    logic [TRIG_W-1:0] rthr_reg, rthr_next;
    logic [BTN_W-1:0]  prev_reg, prev_next;
    in_item_t          cur_reg, cur_next;
    logic [BTN_W-1:0]  press_reg, press_next;
    logic [BTN_W-1:0]  rel_reg, rel_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic signed [AXIS_W-1:0] axis_reg [NUM_AXES];
    logic signed [AXIS_W-1:0] axis_next [NUM_AXES];
    out_item_t         out_reg, out_next;

    logic [AXIS_W-1:0] raw;
    logic [AXIS_W-1:0] mag_full;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  dz;
    logic [MAG_W-1:0]  diff;
    logic [NUM_W-1:0]  num;
    logic              zero;
    logic [MAG_W-1:0]  quotient;
    logic [AXIS_W-1:0] q_ext;
    logic [AXIS_W-1:0] result;
    logic [BTN_W-1:0]  btn;

    // axis magnitude, deadzone test and scaled numerator
    always_comb
    begin
        unique case (cmd.axis_sel)
            AXIS_LX: raw = cur_reg.left_x_in;
            AXIS_LY: raw = cur_reg.left_y_in;
            AXIS_RX: raw = cur_reg.right_x_in;
            AXIS_RY: raw = cur_reg.right_y_in;
            default: raw = '0;
        endcase
        dz       = cmd.axis_sel[1] ? rdz_reg : ldz_reg;
        mag_full = raw[AXIS_W-1] ? (AXIS_W'(0) - raw) : raw;
        mag      = mag_full[AXIS_W-1] ? FULL_SCALE : mag_full[MAG_W-1:0];
        zero     = (dz == FULL_SCALE) || (mag < dz);
        diff     = mag - dz;
        num      = {diff, {MAG_W{1'b0}}} - {{MAG_W{1'b0}}, diff};
    end

    assign sts.axis_zero = zero;

    gdec_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.axis_load),
        .step      (cmd.div_step),
        .numerator (num),
        .divisor   (FULL_SCALE - dz),
        .quotient  (quotient)
    );

    always_comb
    begin
        q_ext  = {1'b0, quotient};
        result = zero_reg ? '0 : (neg_reg ? (AXIS_W'(0) - q_ext) : q_ext);
        btn    = in_data.connected ? in_data.buttons_in : '0;

        ldz_next  = ldz_reg;
        rdz_next  = rdz_reg;
        lthr_next = lthr_reg;
        rthr_next = rthr_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LEFT_DZ:   ldz_next  = cfg_data;
                CFG_RIGHT_DZ:  rdz_next  = cfg_data;
                CFG_LEFT_THR:  lthr_next = cfg_data[TRIG_W-1:0];
                CFG_RIGHT_THR: rthr_next = cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end

        cur_next   = cur_reg;
        prev_next  = prev_reg;
        press_next = press_reg;
        rel_next   = rel_reg;
        if (cmd.capture)
        begin
            cur_next   = in_data.connected ? in_data : '0;
            press_next = btn & ~prev_reg;
            rel_next   = ~btn & prev_reg;
            prev_next  = btn;
        end

        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (cmd.axis_load)
        begin
            neg_next  = raw[AXIS_W-1];
            zero_next = zero;
        end

        axis_next = axis_reg;
        if (cmd.axis_store)
        begin
            axis_next[cmd.axis_sel] = result;
        end

        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_next.buttons_out       = cur_reg.buttons_in;
            out_next.left_x_out        = axis_reg[AXIS_LX];
            out_next.left_y_out        = axis_reg[AXIS_LY];
            out_next.right_x_out       = axis_reg[AXIS_RX];
            out_next.right_y_out       = axis_reg[AXIS_RY];
            out_next.left_trigger_out  = cur_reg.left_trigger_in;
            out_next.right_trigger_out = cur_reg.right_trigger_in;
            out_next.aiming            = cur_reg.left_trigger_in > lthr_reg;
            out_next.shooting          = cur_reg.right_trigger_in > rthr_reg;
            out_next.sprinting         = cur_reg.buttons_in[SPRINT_BIT];
            out_next.pressed_mask      = press_reg;
            out_next.released_mask     = rel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldz_reg  <= RESET_LEFT_DZ;
            rdz_reg  <= RESET_RIGHT_DZ;
            lthr_reg <= RESET_TRIG_THR;
            rthr_reg <= RESET_TRIG_THR;
            prev_reg <= '0;
        end
        else
        begin
            ldz_reg  <= ldz_next;
            rdz_reg  <= rdz_next;
            lthr_reg <= lthr_next;
            rthr_reg <= rthr_next;
            prev_reg <= prev_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        press_reg <= press_next;
        rel_reg   <= rel_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        axis_reg  <= axis_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

>>> rtl/core/gdec_ctrl.sv
// controller: sequences capture, conditioning of the four axes and the output transfer
module gdec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  gdec_pkg::ctrl_sts_t sts,
    output gdec_pkg::ctrl_cmd_t cmd
);
    import gdec_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [AXIS_IDX_W-1:0] axis_reg, axis_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.axis_sel   = axis_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = '0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.axis_load = 1'b1;
                step_next     = '0;
                state_next    = sts.axis_zero ? ST_STORE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.axis_store = 1'b1;
                if (axis_reg == AXIS_IDX_W'(NUM_AXES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
